/* design/fbfla_pkg.sv */
package fbfla_pkg;

  // pool geometry, fixed by the 4-bit block index
  localparam int NUM_BLOCKS = 16;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = $clog2(NUM_BLOCKS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_BLOCKS);

  // register and field widths
  localparam int BB_W   = 13;
  localparam int PB_W   = 17;
  localparam int OFS_W  = 16;
  localparam int ACC_W  = PB_W + 1;
  localparam int PROD_W = IDX_W + BB_W;

  localparam logic [BB_W-1:0] BLOCK_BYTES_RST = BB_W'(64);
  localparam logic [PB_W-1:0] POOL_BYTES_RST  = PB_W'(1024);

  // configuration register indexes
  localparam logic CFG_BLOCK_BYTES = 1'b0;
  localparam logic CFG_POOL_BYTES  = 1'b1;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_FREE    = 2'd2,
    OP_DESTROY = 2'd3
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WAVE = 1'b1
  } state_t;

  // init wavefront handed from cell to cell
  typedef struct packed {
    logic              live;
    logic [ACC_W-1:0]  acc;   // byte offset where this cell's block starts
    logic [LINK_W-1:0] idx;   // index of the cell the wave reaches
    logic [LINK_W-1:0] prev;  // link to write: previous block or null
  } wave_t;

endpackage

/* design/fbfla_cell.sv */
module fbfla_cell
  import fbfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  wave_t             wave_i,
  output wave_t             wave_o,
  input  logic [BB_W-1:0]   block_bytes_i,
  input  logic [PB_W-1:0]   pool_bytes_i,
  input  logic              wr_en_i,
  input  logic [LINK_W-1:0] wr_link_i,
  output logic [LINK_W-1:0] link_o,
  output logic              took_o
);

  logic [LINK_W-1:0] link_r;
  logic [ACC_W-1:0]  end_ofs;
  logic              fits;
  wave_t             wave_r;
  wave_t             wave_nxt;

  // block fits when its size is nonzero and its end does not pass the pool end
  assign end_ofs = wave_i.acc + ACC_W'(block_bytes_i);
  assign fits    = (block_bytes_i != '0) && (end_ofs <= ACC_W'(pool_bytes_i));
  assign took_o  = wave_i.live && fits;

  always_comb begin
    wave_nxt.live = took_o;
    wave_nxt.acc  = end_ofs;
    wave_nxt.idx  = wave_i.idx + LINK_W'(1);
    wave_nxt.prev = wave_i.idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.live <= 1'b0;
    end else begin
      wave_r.live <= wave_nxt.live;
    end
    wave_r.acc  <= wave_nxt.acc;
    wave_r.idx  <= wave_nxt.idx;
    wave_r.prev <= wave_nxt.prev;
  end

  // link entry has no reset, written by init wave or by a free
  always_ff @(posedge clk) begin
    if (took_o) begin
      link_r <= wave_i.prev;
    end else if (wr_en_i) begin
      link_r <= wr_link_i;
    end
  end

  assign wave_o = wave_r;
  assign link_o = link_r;

endmodule

/* design/fixed_block_free_list_allocator_core.sv */
// allocate, free and destroy: result strobe in the cycle after start, one item per cycle while not busy
// init: a wave runs through all 16 link cells, one cell per cycle; the result strobe follows the end of the wave
// init rate is set by the cell chain, busy stays high while the wave is in flight
// results appear for one cycle on out_valid; the receiver cannot stall
// synchronous active-low reset: free list empty, block_bytes 64, pool_bytes 1024
module fixed_block_free_list_allocator_core
  import fbfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // item in
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [IDX_W-1:0]  in_block_index,
  input  logic              in_is_null,
  // result out
  output logic              out_valid,
  output logic              out_ok,
  output logic [IDX_W-1:0]  out_given_index,
  output logic [OFS_W-1:0]  out_byte_offset,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [PB_W-1:0]   cfg_data
);

  // control state
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  wave_cnt_r, wave_cnt_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [BB_W-1:0]   block_bytes_r;
  logic [PB_W-1:0]   pool_bytes_r;

  // result registers
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [IDX_W-1:0]  out_given_index_r, out_given_index_nxt;
  logic [OFS_W-1:0]  out_byte_offset_r, out_byte_offset_nxt;

  // fsm outputs
  logic              seed;
  logic              wave_done;

  // cell chain wiring
  wave_t             wave [NUM_BLOCKS];
  logic [LINK_W-1:0] links [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] took;
  logic [NUM_BLOCKS-1:0] wr_en;

  logic              accept;
  op_t               op;
  logic [PROD_W-1:0] prod;

  assign accept    = start && !busy;
  assign op        = op_t'(in_opcode);
  assign cfg_ready = 1'b1;

  // -------------------------------------------------------------------------
  // state machine: idle takes items, wave walks the init through the cells
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    wave_cnt_nxt = wave_cnt_r;
    case (state_r)
      S_IDLE: begin
        wave_cnt_nxt = '0;
        if (accept && op == OP_INIT) begin
          state_nxt = S_WAVE;
        end
      end
      S_WAVE: begin
        wave_cnt_nxt = wave_cnt_r + IDX_W'(1);
        if (wave_cnt_r == IDX_W'(NUM_BLOCKS - 1)) begin
          state_nxt    = S_IDLE;
          wave_cnt_nxt = '0;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        wave_cnt_nxt = '0;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    seed      = 1'b0;
    wave_done = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_WAVE: begin
        busy      = 1'b1;
        seed      = (wave_cnt_r == '0);
        wave_done = (wave_cnt_r == IDX_W'(NUM_BLOCKS - 1));
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // cell chain: cell i holds the next link of block i
  // the wave enters cell 0 in the first wave cycle and moves one cell a cycle
  // -------------------------------------------------------------------------
  // live, acc, idx, prev: block 0 starts at offset 0 and links to null
  assign wave[0] = {seed, ACC_W'(0), LINK_W'(0), NULL_LINK};

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    if (i < NUM_BLOCKS - 1) begin : g_mid
      fbfla_cell u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .wave_i        (wave[i]),
        .wave_o        (wave[i+1]),
        .block_bytes_i (block_bytes_r),
        .pool_bytes_i  (pool_bytes_r),
        .wr_en_i       (wr_en[i]),
        .wr_link_i     (head_r),
        .link_o        (links[i]),
        .took_o        (took[i])
      );
    end else begin : g_last
      fbfla_cell u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .wave_i        (wave[i]),
        .wave_o        (),
        .block_bytes_i (block_bytes_r),
        .pool_bytes_i  (pool_bytes_r),
        .wr_en_i       (wr_en[i]),
        .wr_link_i     (head_r),
        .link_o        (links[i]),
        .took_o        (took[i])
      );
    end
  end

  // -------------------------------------------------------------------------
  // head update and result for each item
  // -------------------------------------------------------------------------
  assign prod = head_r[IDX_W-1:0] * block_bytes_r;

  always_comb begin
    head_nxt            = head_r;
    wr_en               = '0;
    out_valid_nxt       = 1'b0;
    out_ok_nxt          = 1'b0;
    out_given_index_nxt = '0;
    out_byte_offset_nxt = '0;

    if (accept) begin
      out_valid_nxt = (op != OP_INIT);
      case (op)
        OP_INIT: begin
          // list is rebuilt by the wave, start empty
          head_nxt = NULL_LINK;
        end
        OP_ALLOC: begin
          // pop the head unless the list is empty
          if (head_r < NULL_LINK) begin
            head_nxt            = links[head_r[IDX_W-1:0]];
            out_ok_nxt          = 1'b1;
            out_given_index_nxt = head_r[IDX_W-1:0];
            out_byte_offset_nxt = prod[OFS_W-1:0];
          end
        end
        OP_FREE: begin
          // push as given, no double-free check; null free does nothing
          if (!in_is_null) begin
            wr_en[in_block_index] = 1'b1;
            head_nxt              = {1'b0, in_block_index};
          end
        end
        OP_DESTROY: begin
          head_nxt = NULL_LINK;
        end
        default: begin
          head_nxt = head_r;
        end
      endcase
    end

    // last block chained by the wave becomes the head
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (took[i]) begin
        head_nxt = LINK_W'(i);
      end
    end

    if (wave_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      wave_cnt_r    <= '0;
      head_r        <= NULL_LINK;
      out_valid_r   <= 1'b0;
      block_bytes_r <= BLOCK_BYTES_RST;
      pool_bytes_r  <= POOL_BYTES_RST;
    end else begin
      state_r     <= state_nxt;
      wave_cnt_r  <= wave_cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCK_BYTES: block_bytes_r <= cfg_data[BB_W-1:0];
          CFG_POOL_BYTES:  pool_bytes_r  <= cfg_data;
          default:         pool_bytes_r  <= pool_bytes_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r          <= out_ok_nxt;
    out_given_index_r <= out_given_index_nxt;
    out_byte_offset_r <= out_byte_offset_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_given_index = out_given_index_r;
  assign out_byte_offset = out_byte_offset_r;

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------

  // a result follows either a non-init item or the end of an init wave
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept) && $past(in_opcode) != OP_INIT) || $past(wave_done))
    else $error("result strobe without a matching item");

  // the wave sits in at most one cell at a time
  a_one_cell_takes: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(took))
    else $error("more than one cell took the init wave");

  // head is a block index or the null marker
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= NULL_LINK)
    else $error("head out of range");

  // a failed or non-allocate result carries zeros
  a_zero_when_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_given_index == '0 && out_byte_offset == '0))
    else $error("nonzero payload without ok");

endmodule

/* dv/tb_top.sv */
module tb_top;
  import fbfla_pkg::*;

  // run size and limits
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_GAP      = 14;
  localparam int RAND_ITEMS   = 2000;
  localparam int PHASES       = 10;
  localparam int SHOWN_ERRORS = 40;
  localparam int TAIL_CYCLES  = 20;

  // predictor state: head of the free list, link table, geometry registers
  typedef struct packed {
    logic [LINK_W-1:0]                 head;
    logic [NUM_BLOCKS-1:0][LINK_W-1:0] link;
    logic [BB_W-1:0]                   bb;
    logic [PB_W-1:0]                   pb;
  } pool_t;

  // one result item
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
    logic [OFS_W-1:0] ofs;
  } grant_t;

  // one pending input item plus the idle cycles drawn before it
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             nul;
    logic [3:0]       gap;
  } req_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_opcode = 2'b00;
  logic [IDX_W-1:0]  in_block_index = '0;
  logic              in_is_null = 1'b0;
  logic              out_valid;
  logic              out_ok;
  logic [IDX_W-1:0]  out_given_index;
  logic [OFS_W-1:0]  out_byte_offset;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = 1'b0;
  logic [PB_W-1:0]   cfg_data = '0;

  // pool_now follows accepted items, pool_plan runs ahead with the generator
  pool_t  pool_now;
  pool_t  pool_plan;
  req_t   op_q[$];
  grant_t reply_q[$];
  logic [IDX_W-1:0] owned_q[$];   // blocks the generator believes are handed out

  int          hold_left = 0;
  bit          no_gaps = 1'b0;
  int unsigned cycle_cnt = 0;
  int          err_cnt = 0;
  int          n_live = 0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_inits = 0;
  int          n_granted = 0;
  int          n_dry = 0;
  int          n_writes = 0;

  fixed_block_free_list_allocator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_block_index  (in_block_index),
    .in_is_null      (in_is_null),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_given_index (out_given_index),
    .out_byte_offset (out_byte_offset),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // one step of the allocator: updates the pool and returns the result item
  function automatic grant_t pool_apply(inout pool_t p, input op_t op,
                                        input logic [IDX_W-1:0] idx, input logic nul);
    grant_t                   r;
    int unsigned              cnt;
    int unsigned              i;
    logic [LINK_W-1:0]        blk;
    logic [IDX_W+BB_W-1:0]    prod;
    r = '0;
    case (op)
      OP_INIT: begin
        // block count is pool over block size, zero for a zero block size, capped
        cnt = (p.bb != 0) ? p.pb / p.bb : 0;
        if (cnt > NUM_BLOCKS) cnt = NUM_BLOCKS;
        p.head = NULL_LINK;
        for (i = 0; i < cnt; i++) begin
          p.link[i] = p.head;
          p.head = LINK_W'(i);
        end
      end
      OP_ALLOC: begin
        // pop the head; an empty list gives an all-zero result
        if (p.head < NUM_BLOCKS) begin
          blk = p.head;
          p.head = p.link[blk[IDX_W-1:0]];
          prod = blk[IDX_W-1:0] * p.bb;
          r.ok = 1'b1;
          r.idx = blk[IDX_W-1:0];
          r.ofs = prod[OFS_W-1:0];   // offset wraps to 16 bits
        end
      end
      OP_FREE: begin
        // push as given, no double-free check; null free does nothing
        if (!nul) begin
          p.link[idx] = p.head;
          p.head = LINK_W'(idx);
        end
      end
      default: p.head = NULL_LINK;
    endcase
    return r;
  endfunction

  task automatic flag(input string msg);
    err_cnt++;
    if (err_cnt <= SHOWN_ERRORS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // driver: presents queued items, holds start while busy, idles for the drawn gap
  always @(posedge clk) begin
    req_t   nxt;
    grant_t got;
    logic   fire;
    fire = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
      hold_left = 0;
    end else begin
      if (fire) begin
        // item taken at this edge: predict its result now
        got = pool_apply(pool_now, op_t'(in_opcode), in_block_index, in_is_null);
        reply_q.push_back(got);
        n_accepted++;
        if (op_t'(in_opcode) == OP_INIT) n_inits++;
        if (op_t'(in_opcode) == OP_ALLOC) begin
          if (got.ok) n_granted++;
          else n_dry++;
        end
        hold_left = (op_q.size() != 0) ? int'(op_q[0].gap) : 0;
      end
      if (fire || !start) begin
        if (hold_left != 0 || op_q.size() == 0) begin
          if (hold_left != 0) hold_left--;
          // idle: payload carries junk
          start <= 1'b0;
          in_opcode <= 2'($urandom);
          in_block_index <= IDX_W'($urandom);
          in_is_null <= 1'($urandom);
        end else begin
          nxt = op_q.pop_front();
          start <= 1'b1;
          in_opcode <= nxt.op;
          in_block_index <= nxt.idx;
          in_is_null <= nxt.nul;
        end
      end
    end
  end

  // monitor: every strobed result is checked against the oldest prediction
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        flag("result item with no item outstanding");
      end else begin
        want = reply_q.pop_front();
        n_results++;
        if (out_ok !== want.ok)
          flag($sformatf("ok got %b want %b", out_ok, want.ok));
        if (out_given_index !== want.idx)
          flag($sformatf("given_index got %0d want %0d", out_given_index, want.idx));
        if (out_byte_offset !== want.ofs)
          flag($sformatf("byte_offset got %0d want %0d", out_byte_offset, want.ofs));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d items queued, %0d results outstanding",
               op_q.size(), reply_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // queue one item; the plan copy tells which blocks are handed out
  task automatic push_op(input op_t op, input logic [IDX_W-1:0] idx, input logic nul);
    req_t   r;
    grant_t g;
    int     k;
    g = pool_apply(pool_plan, op, idx, nul);
    if (op == OP_INIT) begin
      owned_q.delete();
    end else if (op == OP_ALLOC && g.ok) begin
      owned_q.push_back(g.idx);
    end else if (op == OP_FREE && !nul) begin
      for (k = 0; k < owned_q.size(); k++) begin
        if (owned_q[k] == idx) begin
          owned_q.delete(k);
          break;
        end
      end
    end
    if (!(op == OP_FREE && nul)) n_live++;
    r.op = op;
    r.idx = idx;
    r.nul = nul;
    r.gap = no_gaps ? 4'd0 : 4'($urandom_range(0, MAX_GAP));
    op_q.push_back(r);
  endtask

  // mostly alloc and free of owned blocks, a few inits and destroys, some noise
  task automatic push_random();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      push_op(OP_INIT, IDX_W'($urandom), 1'($urandom));
    end else if (pick < 4) begin
      push_op(OP_DESTROY, IDX_W'($urandom), 1'($urandom));
    end else if (pick < 20) begin
      push_op(op_t'($urandom_range(0, 3)), IDX_W'($urandom), 1'($urandom));
    end else if (owned_q.size() != 0 && $urandom_range(0, 1) == 1) begin
      k = $urandom_range(0, owned_q.size() - 1);
      push_op(OP_FREE, owned_q[k], 1'b0);
    end else begin
      push_op(OP_ALLOC, IDX_W'($urandom), 1'($urandom));
    end
  endtask

  // wait until every queued item is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (op_q.size() != 0 || start || reply_q.size() != 0);
  endtask

  task automatic write_reg(input logic which, input logic [PB_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_data <= PB_W'($urandom);
    if (which == CFG_BLOCK_BYTES) begin
      pool_now.bb = val[BB_W-1:0];
      pool_plan.bb = val[BB_W-1:0];
    end else begin
      pool_now.pb = val;
      pool_plan.pb = val;
    end
    n_writes++;
  endtask

  // new geometry, written only once the block is idle
  task automatic set_geometry(input int bb, input int pb);
    drain();
    write_reg(CFG_BLOCK_BYTES, PB_W'(bb));
    write_reg(CFG_POOL_BYTES, PB_W'(pb));
    @(negedge clk);
  endtask

  initial begin
    int ph;
    int bb;
    int pb;
    int goal;
    pool_now.head = NULL_LINK;
    pool_now.link = '0;
    pool_now.bb = BB_W'(64);
    pool_now.pb = PB_W'(1024);
    pool_plan = pool_now;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset geometry first: 64-byte blocks in 1024 bytes
    push_op(OP_ALLOC, 4'd0, 1'b0);     // empty list right after reset
    push_op(OP_FREE, 4'd15, 1'b1);     // null free is ignored
    push_op(OP_FREE, 4'd0, 1'b0);      // free before any init
    push_op(OP_ALLOC, 4'd9, 1'b1);
    push_op(OP_ALLOC, 4'd6, 1'b0);     // empty again
    push_op(OP_INIT, 4'd15, 1'b1);     // full pool of 16
    push_op(OP_ALLOC, 4'd0, 1'b0);
    push_op(OP_FREE, 4'd15, 1'b0);
    push_op(OP_FREE, 4'd15, 1'b0);     // double free, pushed as given
    push_op(OP_ALLOC, 4'd0, 1'b0);
    push_op(OP_ALLOC, 4'd0, 1'b0);
    push_op(OP_DESTROY, 4'd10, 1'b1);
    push_op(OP_ALLOC, 4'd0, 1'b0);
    push_op(OP_FREE, 4'd7, 1'b0);      // free after destroy
    push_op(OP_FREE, 4'd3, 1'b0);
    push_op(OP_INIT, 4'd0, 1'b0);      // rebuild on a non-empty list
    push_op(OP_ALLOC, 4'd0, 1'b0);

    // geometry extremes
    set_geometry(0, 131071);           // zero block size, list stays empty
    push_op(OP_INIT, 4'd0, 1'b0);
    push_op(OP_ALLOC, 4'd0, 1'b0);
    set_geometry(8191, 131071);        // offsets wrap past 16 bits
    push_op(OP_INIT, 4'd0, 1'b0);
    push_op(OP_ALLOC, 4'd0, 1'b0);
    set_geometry(8, 0);                // empty pool
    push_op(OP_INIT, 4'd0, 1'b0);
    push_op(OP_ALLOC, 4'd0, 1'b0);
    set_geometry(4096, 65536);         // 4096-byte blocks in 65536 bytes, exactly 16 blocks
    push_op(OP_INIT, 4'd0, 1'b0);
    push_op(OP_ALLOC, 4'd0, 1'b0);

    // random phases, each with its own geometry and idle pattern
    for (ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0: bb = 0;
        1: bb = 8191;
        2: bb = 8;
        3: bb = 4096;
        default: bb = $urandom_range(1, 8191);
      endcase
      if ($urandom_range(0, 4) == 0) begin
        pb = $urandom_range(0, 131071);
      end else begin
        // aim at a block count from 0 to past the cap
        pb = $urandom_range(0, 17) * bb + ((bb > 0) ? $urandom_range(0, bb - 1) : 0);
        if (pb > 131071) pb = 131071;
      end
      set_geometry(bb, pb);
      no_gaps = ($urandom_range(0, 3) == 0);
      push_op(OP_INIT, IDX_W'($urandom), 1'($urandom));
      goal = n_live + RAND_ITEMS / PHASES;
      while (n_live < goal) push_random();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items taken, %0d result items checked, %0d inits, %0d register writes",
             n_accepted, n_results, n_inits, n_writes);
    $display("allocates: %0d handed out a block, %0d found the list empty", n_granted, n_dry);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
